>>> src/tlbf_pkg.sv
// Shared constants, opcodes and control types for the two-level bitmap.
package tlbf_pkg;

    localparam int unsigned DEF_WORD_COUNT = 16;
    localparam int unsigned DEF_WORD_BITS  = 64;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned INDEX_W = 10;

    // index / WORD_BITS is taken as (index * ceil(2^DIV_SHIFT / WORD_BITS)) >> DIV_SHIFT,
    // exact for every 10-bit index and every divisor up to 64
    localparam int unsigned DIV_SHIFT = 17;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

    typedef struct packed {
        logic clear;
        logic update;
        logic is_empty;
        logic is_full;
    } sum_ctl_t;

endpackage

>>> src/tlbf_if.sv
// Request and response channel interfaces of the two-level bitmap.
interface tlbf_req_if;
    logic                              valid;
    logic                              ready;
    logic [tlbf_pkg::OP_W-1:0]         op;
    logic [tlbf_pkg::INDEX_W-1:0]      bit_index;
    logic                              bit_value;

    modport source (output valid, output op, output bit_index, output bit_value, input ready);
    modport sink   (input valid, input op, input bit_index, input bit_value, output ready);
endinterface

interface tlbf_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              read_bit;
    logic                              found;
    logic [tlbf_pkg::INDEX_W-1:0]      found_index;

    modport source (output valid, output read_bit, output found, output found_index, input ready);
    modport sink   (input valid, input read_bit, input found, input found_index, output ready);
endinterface

>>> src/two_level_bitmap_find_first.sv
// Top level: request decode, read-modify-write sequencer and response register.
//
//   channel  dir  fields                                   accepted when
//   req      in   op[1:0] bit_index[9:0] bit_value         req.valid && req.ready
//   rsp      out  read_bit found found_index[9:0]          rsp.valid && rsp.ready
//
// Write, read and find read the word store on accept, then do the
// modify/write-back or bit search on the next cycle. Clear has no execute step.
// The word store has one read and one write port; the sequencer holds
// req.ready low during the execute step. Reset is immediate: valid bits
// and summaries clear at once, no sweep. A stalled rsp holds the next request.
module two_level_bitmap_find_first #(
    parameter int unsigned WORD_COUNT = tlbf_pkg::DEF_WORD_COUNT,
    parameter int unsigned WORD_BITS  = tlbf_pkg::DEF_WORD_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    tlbf_req_if.sink   req,
    tlbf_rsp_if.source rsp
);

    localparam int unsigned WI_W  = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int unsigned BI_W  = $clog2(WORD_BITS);
    localparam int unsigned IW    = tlbf_pkg::INDEX_W;
    localparam int unsigned SH    = tlbf_pkg::DIV_SHIFT;
    localparam int unsigned RCP_W = SH + 1;
    localparam int unsigned PRD_W = IW + RCP_W;
    localparam logic [RCP_W-1:0] RECIP = RCP_W'(((1 << SH) + WORD_BITS - 1) / WORD_BITS);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg, state_next;

    logic [tlbf_pkg::OP_W-1:0] op_reg;
    logic                      val_reg;
    logic [WI_W-1:0]           word_reg;
    logic [BI_W-1:0]           bit_reg;
    logic                      inrange_reg;
    logic                      cand_any_reg;

    logic                      rsp_valid_reg, rsp_valid_next;
    logic                      read_bit_reg;
    logic                      found_reg;
    logic [IW-1:0]             found_index_reg;

    logic [PRD_W-1:0]          prod;
    logic [IW-1:0]             quot;
    logic [IW-1:0]             rem;
    logic                      in_range;
    logic [WI_W-1:0]           word_idx;

    logic                      accept;
    logic                      cand_any;
    logic [WI_W-1:0]           cand_word;
    logic [WORD_BITS-1:0]      rd_data;
    logic [WORD_BITS-1:0]      bit_mask;
    logic [WORD_BITS-1:0]      new_word;
    logic [WORD_BITS-1:0]      hits;
    logic [BI_W-1:0]           hit_bit;
    logic                      do_write;
    logic                      exec_load;
    tlbf_pkg::sum_ctl_t        sum_ctl;

    assign req.ready = (state_reg == S_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    // index split into word and bit by reciprocal multiply
    assign prod     = PRD_W'(req.bit_index) * PRD_W'(RECIP);
    assign quot     = prod[SH +: IW];
    assign rem      = req.bit_index - IW'(quot * IW'(WORD_BITS));
    assign in_range = quot < IW'(WORD_COUNT);
    assign word_idx = in_range ? quot[WI_W-1:0] : '0;

    tlbf_summary #(
        .WORD_COUNT (WORD_COUNT)
    ) u_summary (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sum_ctl),
        .upd_word   (word_reg),
        .find_value (req.bit_value),
        .cand_any   (cand_any),
        .cand_word  (cand_word)
    );

    tlbf_word_store #(
        .WORD_COUNT (WORD_COUNT),
        .WORD_BITS  (WORD_BITS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (sum_ctl.clear),
        .rd_en   (accept),
        .rd_addr ((req.op == tlbf_pkg::OP_FIND) ? cand_word : word_idx),
        .wr_en   (do_write),
        .wr_addr (word_reg),
        .wr_data (new_word),
        .rd_data (rd_data)
    );

    assign exec_load = (state_reg == S_EXEC);
    assign do_write  = exec_load && (op_reg == tlbf_pkg::OP_WRITE) && inrange_reg;
    assign bit_mask  = WORD_BITS'(1) << bit_reg;
    assign new_word  = val_reg ? (rd_data | bit_mask) : (rd_data & ~bit_mask);
    assign hits      = val_reg ? rd_data : ~rd_data;

    assign sum_ctl.clear    = accept && (req.op == tlbf_pkg::OP_CLEAR);
    assign sum_ctl.update   = do_write;
    assign sum_ctl.is_empty = (new_word == '0);
    assign sum_ctl.is_full  = (new_word == '1);

    always_comb
    begin
        hit_bit = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (hits[i])
            begin
                hit_bit = BI_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (req.op != tlbf_pkg::OP_CLEAR))
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (exec_load || sum_ctl.clear)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= req.op;
            val_reg      <= req.bit_value;
            word_reg     <= (req.op == tlbf_pkg::OP_FIND) ? cand_word : word_idx;
            bit_reg      <= rem[BI_W-1:0];
            inrange_reg  <= in_range;
            cand_any_reg <= cand_any;
        end
        if (sum_ctl.clear)
        begin
            read_bit_reg    <= 1'b0;
            found_reg       <= 1'b0;
            found_index_reg <= '0;
        end
        else if (exec_load)
        begin
            read_bit_reg    <= (op_reg == tlbf_pkg::OP_READ) && inrange_reg && rd_data[bit_reg];
            found_reg       <= (op_reg == tlbf_pkg::OP_FIND) && cand_any_reg && (|hits);
            found_index_reg <= ((op_reg == tlbf_pkg::OP_FIND) && cand_any_reg && (|hits))
                ? IW'(int'(word_reg) * int'(WORD_BITS) + int'(hit_bit)) : '0;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_bit    = read_bit_reg;
    assign rsp.found       = found_reg;
    assign rsp.found_index = found_index_reg;

endmodule

>>> src/tlbf_word_store.sv
// Word memory with registered read and per-word valid bits.
module tlbf_word_store #(
    parameter int unsigned WORD_COUNT = tlbf_pkg::DEF_WORD_COUNT,
    parameter int unsigned WORD_BITS  = tlbf_pkg::DEF_WORD_BITS,
    localparam int unsigned WI_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 rd_en,
    input  logic [WI_W-1:0]      rd_addr,
    input  logic                 wr_en,
    input  logic [WI_W-1:0]      wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0]  mem [WORD_COUNT];
    logic [WORD_BITS-1:0]  data_reg;
    logic [WORD_COUNT-1:0] valid_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // words not written since reset or the last clear read as zero
    assign rd_data = rd_valid_reg ? data_reg : '0;

endmodule

>>> src/tlbf_summary.sv
// All-zero and all-ones word summaries with lowest-candidate-word encoder.
module tlbf_summary #(
    parameter int unsigned WORD_COUNT = tlbf_pkg::DEF_WORD_COUNT,
    localparam int unsigned WI_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tlbf_pkg::sum_ctl_t ctl,
    input  logic [WI_W-1:0]    upd_word,
    input  logic               find_value,
    output logic               cand_any,
    output logic [WI_W-1:0]    cand_word
);

    logic [WORD_COUNT-1:0] empty_reg;
    logic [WORD_COUNT-1:0] full_reg;
    logic [WORD_COUNT-1:0] cand;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            empty_reg <= '1;
            full_reg  <= '0;
        end
        else if (ctl.clear)
        begin
            empty_reg <= '1;
            full_reg  <= '0;
        end
        else if (ctl.update)
        begin
            empty_reg[upd_word] <= ctl.is_empty;
            full_reg[upd_word]  <= ctl.is_full;
        end
    end

    // words that may hold the value: not all-ones for 0, not all-zero for 1
    assign cand     = find_value ? ~empty_reg : ~full_reg;
    assign cand_any = |cand;

    always_comb
    begin
        cand_word = '0;
        for (int i = WORD_COUNT - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                cand_word = WI_W'(i);
            end
        end
    end

endmodule

>>> src/tlbf_check.sv
// Port-level checker for the two-level bitmap, bound to the top level.
module tlbf_check (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic [tlbf_pkg::OP_W-1:0]    req_op,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic                         rsp_read_bit,
    input logic                         rsp_found,
    input logic [tlbf_pkg::INDEX_W-1:0] rsp_found_index
);

    logic req_acc;
    assign req_acc = req_valid && req_ready;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && (req_op != tlbf_pkg::OP_CLEAR) |=> !req_ready)
        else $error("request taken during read-modify-write");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && (req_op != tlbf_pkg::OP_CLEAR) |-> ##2 rsp_valid)
        else $error("response missing two cycles after request");

    a_clear_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && (req_op == tlbf_pkg::OP_CLEAR) |=>
            rsp_valid && !rsp_read_bit && !rsp_found && (rsp_found_index == '0))
        else $error("clear response not all zero");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_read_bit && rsp_found) && (rsp_found || (rsp_found_index == '0)))
        else $error("inconsistent response fields");

endmodule

bind two_level_bitmap_find_first tlbf_check u_tlbf_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_op          (req.op),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_read_bit    (rsp.read_bit),
    .rsp_found       (rsp.found),
    .rsp_found_index (rsp.found_index)
);

>>> tb/tb.sv
// Self-checking testbench for the two-level bitmap find-first block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tlbf_pkg::*;

    localparam int unsigned WORD_COUNT = DEF_WORD_COUNT;
    localparam int unsigned WORD_BITS  = DEF_WORD_BITS;
    localparam int unsigned MAP_BITS   = WORD_COUNT * WORD_BITS;
    localparam int unsigned REQ_TARGET = 1950;
    localparam int unsigned MAX_SHOWN  = 10;

    typedef struct packed {
        logic               hold;
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] bit_index;
        logic               bit_value;
    } bitmap_req_t;

    typedef struct packed {
        logic               read_bit;
        logic               found;
        logic [INDEX_W-1:0] found_index;
    } bitmap_rsp_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic               req_valid_q = 1'b0;
    logic [OP_W-1:0]    req_op_q    = OP_READ;
    logic [INDEX_W-1:0] req_index_q = '0;
    logic               req_value_q = 1'b0;
    logic               rsp_ready_q = 1'b0;

    tlbf_req_if req_ch ();
    tlbf_rsp_if rsp_ch ();

    assign req_ch.valid     = req_valid_q;
    assign req_ch.op        = req_op_q;
    assign req_ch.bit_index = req_index_q;
    assign req_ch.bit_value = req_value_q;
    assign rsp_ch.ready     = rsp_ready_q;

    two_level_bitmap_find_first dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // shadow copy of the bitmap and its summaries
    logic [WORD_BITS-1:0]  model_words [WORD_COUNT];
    logic [WORD_COUNT-1:0] model_empty;
    logic [WORD_COUNT-1:0] model_full;

    bitmap_req_t pending_reqs [$];
    bitmap_rsp_t expected_rsps [$];

    int unsigned op_count [4];
    int unsigned find_hits;
    int unsigned find_misses;
    int unsigned rsp_count;
    int unsigned error_count;
    int unsigned queued_reqs;
    int unsigned drains_done;

    function automatic void clear_model();
        for (int i = 0; i < WORD_COUNT; i++)
            model_words[i] = '0;
        model_empty = '1;
        model_full  = '0;
    endfunction

    function automatic bitmap_rsp_t apply_request(bitmap_req_t r);
        bitmap_rsp_t           res;
        int unsigned           w;
        int unsigned           b;
        int                    k_sel;
        int                    b_sel;
        logic [WORD_COUNT-1:0] cand;
        logic [WORD_BITS-1:0]  hits;
        res   = '0;
        w     = r.bit_index / WORD_BITS;
        b     = r.bit_index % WORD_BITS;
        k_sel = -1;
        b_sel = -1;
        op_count[r.op]++;
        case (r.op)
            OP_WRITE:
            begin
                if (w < WORD_COUNT)
                begin
                    model_words[w][b] = r.bit_value;
                    if (r.bit_value)
                    begin
                        model_empty[w] = 1'b0;
                        if (&model_words[w])
                            model_full[w] = 1'b1;
                    end
                    else
                    begin
                        model_full[w] = 1'b0;
                        if (model_words[w] == '0)
                            model_empty[w] = 1'b1;
                    end
                end
            end
            OP_READ:
            begin
                if (w < WORD_COUNT)
                    res.read_bit = model_words[w][b];
            end
            OP_FIND:
            begin
                cand = r.bit_value ? ~model_empty : ~model_full;
                for (int k = WORD_COUNT - 1; k >= 0; k--)
                    if (cand[k])
                        k_sel = k;
                if (k_sel >= 0)
                begin
                    hits = r.bit_value ? model_words[k_sel] : ~model_words[k_sel];
                    for (int k = WORD_BITS - 1; k >= 0; k--)
                        if (hits[k])
                            b_sel = k;
                end
                if (b_sel >= 0)
                begin
                    res.found       = 1'b1;
                    res.found_index = INDEX_W'(k_sel * WORD_BITS + b_sel);
                    find_hits++;
                end
                else
                    find_misses++;
            end
            default:
                clear_model();
        endcase
        return res;
    endfunction

    function automatic void note_error(string msg);
        error_count++;
        if (error_count <= MAX_SHOWN)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // request driver: bursts with random gaps, drain markers hold off until idle
    int unsigned burst_left = 8;
    int unsigned gap_left   = 0;
    bitmap_req_t cur_req;

    always @(posedge clk or negedge rst_n)
    begin
        logic present;
        if (!rst_n)
        begin
            req_valid_q <= 1'b0;
        end
        else
        begin
            present = req_valid_q;
            if (req_valid_q && req_ch.ready)
            begin
                expected_rsps.push_back(apply_request(cur_req));
                present = 1'b0;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                              : $urandom_range(1, 16);
                end
            end
            if (!present)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (pending_reqs.size() > 0)
                begin
                    if (pending_reqs[0].hold)
                    begin
                        if (expected_rsps.size() == 0)
                        begin
                            void'(pending_reqs.pop_front());
                            drains_done++;
                        end
                    end
                    else
                    begin
                        cur_req = pending_reqs.pop_front();
                        present = 1'b1;
                    end
                end
            end
            req_valid_q <= present;
            if (present)
            begin
                req_op_q    <= cur_req.op;
                req_index_q <= cur_req.bit_index;
                req_value_q <= cur_req.bit_value;
            end
        end
    end

    // response monitor with its own stall pattern
    int unsigned cycle_cnt  = 0;
    int unsigned stall_mode = 0;

    always @(posedge clk or negedge rst_n)
    begin
        bitmap_rsp_t want;
        logic        next_ready;
        if (!rst_n)
        begin
            rsp_ready_q <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_count++;
                if (expected_rsps.size() == 0)
                    note_error($sformatf("unexpected response read_bit=%0b found=%0b index=%0d",
                                         rsp_ch.read_bit, rsp_ch.found, rsp_ch.found_index));
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_ch.read_bit !== want.read_bit || rsp_ch.found !== want.found ||
                        rsp_ch.found_index !== want.found_index)
                        note_error($sformatf({"response %0d: expected read_bit=%0b found=%0b ",
                                              "index=%0d, got read_bit=%0b found=%0b index=%0d"},
                                             rsp_count, want.read_bit, want.found,
                                             want.found_index, rsp_ch.read_bit, rsp_ch.found,
                                             rsp_ch.found_index));
                end
            end
            cycle_cnt++;
            if (cycle_cnt % 256 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0:       next_ready = 1'b1;
                1:       next_ready = 1'($urandom_range(0, 1));
                2:       next_ready = (cycle_cnt % 7) >= 3;
                default: next_ready = ((cycle_cnt / 8) % 8) != 5;
            endcase
            rsp_ready_q <= next_ready;
        end
    end

    int unsigned order [MAP_BITS];

    task automatic push_req(input logic [OP_W-1:0] op, input int unsigned idx, input logic v);
        bitmap_req_t r;
        r.hold      = 1'b0;
        r.op        = op;
        r.bit_index = INDEX_W'(idx);
        r.bit_value = v;
        pending_reqs.push_back(r);
        queued_reqs++;
    endtask

    task automatic push_drain();
        bitmap_req_t r;
        r      = '0;
        r.hold = 1'b1;
        pending_reqs.push_back(r);
    endtask

    task automatic shuffle_order(input int unsigned n);
        int unsigned j;
        int unsigned t;
        for (int unsigned i = 0; i < n; i++)
            order[i] = i;
        for (int unsigned i = n - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            t        = order[i];
            order[i] = order[j];
            order[j] = t;
        end
    endtask

    initial
    begin
        int unsigned w;
        int unsigned n;
        int unsigned pick;
        int unsigned idx;
        logic [OP_W-1:0] op;

        clear_model();

        // directed: empty map, corner indices, word going empty again, clear
        push_req(OP_FIND, 10'h3FF, 1'b1);
        push_req(OP_FIND, 10'h000, 1'b0);
        push_req(OP_READ, 0, 1'b0);
        push_req(OP_READ, 1023, 1'b1);
        push_req(OP_WRITE, 0, 1'b1);
        push_req(OP_WRITE, 1023, 1'b1);
        push_req(OP_WRITE, 512, 1'b1);
        push_req(OP_READ, 0, 1'b0);
        push_req(OP_READ, 1023, 1'b0);
        push_req(OP_READ, 512, 1'b1);
        push_req(OP_FIND, 10'h2AA, 1'b1);
        push_req(OP_FIND, 10'h155, 1'b0);
        push_req(OP_WRITE, 0, 1'b0);
        push_req(OP_FIND, 0, 1'b1);
        push_req(OP_WRITE, 511, 1'b0);
        push_req(OP_READ, 511, 1'b1);
        push_req(OP_CLEAR, 10'h3FF, 1'b1);
        push_req(OP_READ, 1023, 1'b0);
        push_req(OP_FIND, 0, 1'b1);
        push_req(OP_WRITE, 1023, 1'b1);
        push_req(OP_FIND, 0, 1'b1);
        push_req(OP_WRITE, 1023, 1'b0);
        push_req(OP_FIND, 0, 1'b1);
        push_drain();

        // fill the whole map in random order until no zero is left
        shuffle_order(MAP_BITS);
        for (int unsigned i = 0; i < MAP_BITS; i++)
        begin
            push_req(OP_WRITE, order[i], 1'b1);
            if (i % 40 == 39)
            begin
                push_req(OP_FIND, $urandom_range(0, 1023), 1'b0);
                push_req(OP_FIND, $urandom_range(0, 1023), 1'b1);
                push_req(OP_READ, $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
            end
        end
        push_req(OP_FIND, $urandom_range(0, 1023), 1'b0);
        push_req(OP_FIND, $urandom_range(0, 1023), 1'b1);
        for (int i = 0; i < 4; i++)
        begin
            idx = $urandom_range(0, MAP_BITS - 1);
            push_req(OP_WRITE, idx, 1'b0);
            push_req(OP_FIND, $urandom_range(0, 1023), 1'b0);
            push_req(OP_READ, idx, 1'b1);
            push_req(OP_WRITE, idx, 1'b1);
        end
        push_drain();
        push_req(OP_CLEAR, $urandom_range(0, 1023), 1'($urandom_range(0, 1)));

        // per-word fills and noise
        w = 0;
        while (queued_reqs < REQ_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 4)
            begin
                w = $urandom_range(0, WORD_COUNT - 1);
                n = ($urandom_range(0, 2) == 0) ? $urandom_range(40, WORD_BITS - 1) : WORD_BITS;
                shuffle_order(WORD_BITS);
                for (int unsigned i = 0; i < n; i++)
                begin
                    push_req(OP_WRITE, w * WORD_BITS + order[i], 1'b1);
                    if (i % 16 == 15)
                    begin
                        push_req(OP_FIND, $urandom_range(0, 1023), 1'b0);
                        push_req(OP_FIND, $urandom_range(0, 1023), 1'b1);
                    end
                end
                push_req(OP_FIND, $urandom_range(0, 1023), 1'b0);
                push_req(OP_FIND, $urandom_range(0, 1023), 1'b1);
                idx = w * WORD_BITS + $urandom_range(0, WORD_BITS - 1);
                push_req(OP_WRITE, idx, 1'b0);
                push_req(OP_FIND, $urandom_range(0, 1023), 1'b0);
                push_req(OP_READ, idx, 1'($urandom_range(0, 1)));
            end
            else if (pick <= 8)
            begin
                n = $urandom_range(8, 30);
                for (int unsigned i = 0; i < n; i++)
                begin
                    op  = ($urandom_range(0, 39) == 0) ? OP_CLEAR : OP_W'($urandom_range(0, 2));
                    idx = $urandom_range(0, 1) ? w * WORD_BITS + $urandom_range(0, WORD_BITS - 1)
                                               : $urandom_range(0, MAP_BITS - 1);
                    push_req(op, idx, 1'($urandom_range(0, 1)));
                end
            end
            else
                push_req(OP_CLEAR, $urandom_range(0, 1023), 1'($urandom_range(0, 1)));
            if ($urandom_range(0, 5) == 0)
                push_drain();
        end

        wait (rst_n);
        while (pending_reqs.size() > 0 || req_valid_q || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (expected_rsps.size() > 0)
            note_error($sformatf("%0d responses never arrived", expected_rsps.size()));

        $display("Covered %0d requests: %0d writes, %0d reads, %0d finds, %0d clears",
                 op_count[OP_WRITE] + op_count[OP_READ] + op_count[OP_FIND] + op_count[OP_CLEAR],
                 op_count[OP_WRITE], op_count[OP_READ], op_count[OP_FIND], op_count[OP_CLEAR]);
        $display("Finds hit %0d, missed %0d; full-map fill, word fills, %0d idle drains; %0d errors",
                 find_hits, find_misses, drains_done, error_count);
        if (error_count == 0)
            $display("two_level_bitmap_find_first verification clean");
        else
            $display("two_level_bitmap_find_first verification failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout: %0d responses still expected", expected_rsps.size());
        $display("two_level_bitmap_find_first verification failed");
        $finish;
    end

endmodule

>>> filelist.f
src/tlbf_pkg.sv
src/tlbf_if.sv
src/tlbf_word_store.sv
src/tlbf_summary.sv
src/two_level_bitmap_find_first.sv
src/tlbf_check.sv
tb/tb.sv
